### rtl/sliding_window_max_heap_assert.svh
// Assertion macros for the sliding-window max heap block.
// Used by the RTL file that carries concurrent checks.
`ifndef SLIDING_WINDOW_MAX_HEAP_ASSERT_SVH
`define SLIDING_WINDOW_MAX_HEAP_ASSERT_SVH
`ifndef SYNTHESIS
`define SWMH_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
`define SWMH_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SWMH_ASSERT_IMP(label, clk, rstn, ante, cons, msg)
`define SWMH_ASSERT_NXT(label, clk, rstn, ante, cons, msg)
`endif
`endif

### rtl/swmh_pkg.sv
// Package for the sliding-window max heap: sizes, item types, status and state codes.
// No dependencies.
`default_nettype none
package swmh_pkg;
    localparam int HEAP_DEPTH = 1024;
    localparam int AW = $clog2(HEAP_DEPTH);
    localparam int CW = $clog2(HEAP_DEPTH + 1);

    typedef logic [AW-1:0] addr_t;
    typedef logic [CW-1:0] count_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_FULL     = 2'd2,
        ST_ADV_IGN  = 2'd3
    } status_t;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_ADVANCE = 1'b1;

    typedef struct packed {
        logic               op;
        logic signed [31:0] value;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] max_value;
        logic [31:0]        max_position;
        logic [1:0]         status;
    } out_item_t;

    typedef struct packed {
        logic signed [31:0] value;
        logic [31:0]        position;
    } entry_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_UP_RD,      // read parent
        S_UP_CMP,     // compare, swap
        S_TOP_RD,     // read root
        S_TOP_CHK,    // expiry check
        S_POP_RD,     // read last entry
        S_POP_WR,     // latch last entry, restart at root
        S_DN_RD_L,    // read left child
        S_DN_RD_R,    // read right child
        S_DN_CMP,     // choose and swap
        S_REPORT
    } state_t;

    // signed compare a < b
    function automatic logic val_less(input logic signed [31:0] a,
                                      input logic signed [31:0] b);
        val_less = (a < b);
    endfunction
endpackage
`default_nettype wire

### rtl/swmh_ram.sv
// Single-port heap entry memory, registered read.
// Depends on swmh_pkg.
`default_nettype none
module swmh_ram
    import swmh_pkg::*;
(
    input  wire logic   aclk,
    input  wire logic   we,
    input  wire addr_t  addr,
    input  wire entry_t wdata,
    output entry_t      rdata
);
    entry_t mem [HEAP_DEPTH];
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule
`default_nettype wire

### rtl/sliding_window_max_heap.sv
// Channel | dir | payload    | handshake
// s_      | in  | in_item_t  | s_valid / s_ready
// m_      | out | out_item_t | m_valid / m_ready
// One item at a time; s_ready is high only while the sequencer is idle.
// After accept, a push sifts up (S_UP_RD, S_UP_CMP per level) toward the root, while an
// advance or a dropped push goes to S_TOP_RD; each expired top is popped (S_POP_RD,
// S_POP_WR) and sunk (S_DN_RD_L, S_DN_RD_R, S_DN_CMP). S_REPORT then returns to S_IDLE.
// The single-port heap memory sets the rate: at most one read or write each cycle.
// Synchronous active-low reset clears counters, the sequencer and m_valid; no clearing pass.
// The result register holds until m_ready; a finished item waits in S_REPORT for it.
// Depends on swmh_pkg, swmh_ram and sliding_window_max_heap_assert.svh.
`default_nettype none
`include "sliding_window_max_heap_assert.svh"
module sliding_window_max_heap
    import swmh_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire in_item_t  s_data,
    output logic           m_valid,
    input  wire logic      m_ready,
    output out_item_t      m_data
);
    state_t    state_reg, state_next;
    count_t    count_reg, count_next;
    logic [31:0] left_reg, left_next, npos_reg, npos_next;
    addr_t     k_reg, k_next;
    entry_t    cur_reg, cur_next;     // entry being sifted
    entry_t    lch_reg, lch_next;     // left child
    logic [1:0] stat_reg, stat_next;
    logic      mv_reg, mv_next;
    out_item_t out_reg, out_next;

    logic   we;
    addr_t  addr;
    entry_t wdata, rdata;

    swmh_ram u_ram (.aclk(aclk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata));

    addr_t parent;
    logic [AW+1:0] lidx, ridx, cnt_ext;
    logic expired, up_go, has_l, pick_l, pick_r, dn_go, out_free;

    assign parent = addr_t'((k_reg - addr_t'(1)) >> 1);
    assign lidx = {1'b0, k_reg, 1'b1};
    assign ridx = {1'b0, k_reg, 1'b0} + (AW+2)'(2);
    assign cnt_ext = (AW+2)'(count_reg);
    assign has_l = lidx < cnt_ext;
    assign expired = (npos_reg - rdata.position) > (npos_reg - left_reg);
    // sift-up: rdata is the parent
    assign up_go = val_less(rdata.value, cur_reg.value);
    // sift-down: lch_reg is left child, rdata is right child (if any)
    assign pick_l = val_less(cur_reg.value, lch_reg.value);
    assign pick_r = (ridx < cnt_ext) && val_less(cur_reg.value, rdata.value)
                    && val_less(lch_reg.value, rdata.value);
    assign dn_go = pick_l || pick_r;
    assign out_free = !mv_reg || m_ready;

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = mv_reg;
    assign m_data  = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            left_reg  <= '0;
            npos_reg  <= '0;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            left_reg  <= left_next;
            npos_reg  <= npos_next;
            mv_reg    <= mv_next;
        end
        k_reg    <= k_next;
        cur_reg  <= cur_next;
        lch_reg  <= lch_next;
        stat_reg <= stat_next;
        out_reg  <= out_next;
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    if (s_data.op == OP_PUSH && count_reg != count_t'(HEAP_DEPTH)) begin
                        state_next = S_UP_RD;
                    end else begin
                        state_next = S_TOP_RD;
                    end
                end
            end
            S_UP_RD: begin
                if (k_reg == '0) begin
                    state_next = S_TOP_RD;
                end else begin
                    state_next = S_UP_CMP;
                end
            end
            S_UP_CMP: begin
                if (up_go) begin
                    state_next = S_UP_RD;
                end else begin
                    state_next = S_TOP_RD;
                end
            end
            S_TOP_RD:  state_next = S_TOP_CHK;
            S_TOP_CHK: begin
                if (count_reg != '0 && expired) begin
                    state_next = S_POP_RD;
                end else begin
                    state_next = S_REPORT;
                end
            end
            S_POP_RD:  state_next = S_POP_WR;
            S_POP_WR: begin
                if (count_reg == '0) begin
                    state_next = S_TOP_RD;
                end else begin
                    state_next = S_DN_RD_L;
                end
            end
            S_DN_RD_L: begin
                if (has_l) begin
                    state_next = S_DN_RD_R;
                end else begin
                    state_next = S_TOP_RD;
                end
            end
            S_DN_RD_R: state_next = S_DN_CMP;
            S_DN_CMP: begin
                if (dn_go) begin
                    state_next = S_DN_RD_L;
                end else begin
                    state_next = S_TOP_RD;
                end
            end
            S_REPORT: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default:   state_next = S_IDLE;
        endcase
    end

    // outputs and datapath; the moving entry stays in cur_reg and lands in the hole last
    always_comb begin
        we = 1'b0;
        addr = k_reg;
        wdata = cur_reg;
        count_next = count_reg;
        left_next = left_reg;
        npos_next = npos_reg;
        k_next = k_reg;
        cur_next = cur_reg;
        lch_next = lch_reg;
        stat_next = stat_reg;
        mv_next = mv_reg && !m_ready;
        out_next = out_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    stat_next = ST_OK;
                    if (s_data.op == OP_PUSH) begin
                        if (count_reg == count_t'(HEAP_DEPTH)) begin
                            stat_next = ST_FULL;
                        end else begin
                            cur_next = '{value: s_data.value, position: npos_reg};
                            k_next = addr_t'(count_reg);
                            npos_next = npos_reg + 32'd1;
                            count_next = count_reg + count_t'(1);
                        end
                    end else if (left_reg == npos_reg) begin
                        stat_next = ST_ADV_IGN;
                    end else begin
                        left_next = left_reg + 32'd1;
                    end
                end
            end
            S_UP_RD: begin
                if (k_reg == '0) begin
                    we = 1'b1;
                    addr = '0;
                end else begin
                    addr = parent;
                end
            end
            S_UP_CMP: begin
                we = 1'b1;
                if (up_go) begin
                    wdata = rdata;       // parent moves down
                    k_next = parent;
                end
            end
            S_TOP_RD:  addr = '0;
            S_TOP_CHK: cur_next = rdata;
            S_POP_RD: begin
                count_next = count_reg - count_t'(1);
                addr = addr_t'(count_reg - count_t'(1));
            end
            S_POP_WR: begin
                cur_next = rdata;
                k_next = '0;
            end
            S_DN_RD_L: begin
                if (has_l) begin
                    addr = lidx[AW-1:0];
                end else begin
                    we = 1'b1;
                end
            end
            S_DN_RD_R: begin
                addr = ridx[AW-1:0];
                lch_next = rdata;
            end
            S_DN_CMP: begin
                we = 1'b1;
                if (pick_r) begin
                    wdata = rdata;
                    k_next = ridx[AW-1:0];
                end else if (pick_l) begin
                    wdata = lch_reg;
                    k_next = lidx[AW-1:0];
                end
            end
            S_REPORT: begin
                if (out_free) begin
                    mv_next = 1'b1;
                    if (count_reg == '0) begin
                        out_next.max_value = '0;
                        out_next.max_position = '0;
                        out_next.status = (stat_reg == ST_OK) ? ST_EMPTY : stat_reg;
                    end else begin
                        out_next.max_value = cur_reg.value;
                        out_next.max_position = cur_reg.position;
                        out_next.status = stat_reg;
                    end
                end
            end
            default: ;
        endcase
    end

    `SWMH_ASSERT_IMP(a_cnt_max, aclk, aresetn, 1'b1, count_reg <= count_t'(HEAP_DEPTH), "count overflow")
    `SWMH_ASSERT_NXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, $stable(m_data), "result changed")
    `SWMH_ASSERT_IMP(a_busy, aclk, aresetn, state_reg != S_IDLE, !s_ready, "ready while busy")
    `SWMH_ASSERT_IMP(a_empty_zero, aclk, aresetn, m_valid && m_data.status == ST_EMPTY, m_data.max_value == 0, "empty with value")
endmodule
`default_nettype wire

### test/testbench.sv
// Self-checking bench for the sliding-window max heap: directed and random push/advance items.
// Depends on swmh_pkg and the sliding_window_max_heap RTL.
`timescale 1ns / 1ps
module testbench;
    import swmh_pkg::*;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_data = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_data;

    sliding_window_max_heap u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // predictor state
    logic signed [31:0] pv [HEAP_DEPTH];
    logic [31:0]        pp [HEAP_DEPTH];
    int unsigned        p_count;
    logic [31:0]        p_left;
    logic [31:0]        p_next;

    out_item_t window_max_q[$];
    int errors = 0;
    int n_sent = 0;
    int n_checked = 0;
    int n_full = 0;
    int n_ign = 0;
    bit hold_off = 1'b0;
    bit burst_mode = 1'b1;

    function automatic void heap_swap(int unsigned a, int unsigned b);
        logic signed [31:0] tv;
        logic [31:0] tp;
        tv = pv[a]; pv[a] = pv[b]; pv[b] = tv;
        tp = pp[a]; pp[a] = pp[b]; pp[b] = tp;
    endfunction

    function automatic void heap_sink();
        int unsigned k, l, r, pick;
        k = 0;
        while (k < p_count) begin
            l = 2 * k + 1;
            r = 2 * k + 2;
            pick = k;
            if (l < p_count && pv[k] < pv[l]) pick = l;
            if (r < p_count && pv[k] < pv[r] && pv[l] < pv[r]) pick = r;
            if (pick == k) break;
            heap_swap(k, pick);
            k = pick;
        end
    endfunction

    function automatic out_item_t predict_window_max(in_item_t it);
        out_item_t res;
        logic [1:0] st;
        int unsigned k;
        st = ST_OK;
        if (it.op == OP_PUSH) begin
            if (p_count >= HEAP_DEPTH) begin
                st = ST_FULL;
            end else begin
                pv[p_count] = it.value;
                pp[p_count] = p_next;
                p_next++;
                p_count++;
                k = p_count - 1;
                while (k > 0 && pv[(k - 1) / 2] < pv[k]) begin
                    heap_swap((k - 1) / 2, k);
                    k = (k - 1) / 2;
                end
            end
        end else begin
            if (p_left == p_next) st = ST_ADV_IGN;
            else p_left++;
        end
        // lazy expiry of stale tops
        while (p_count > 0 && (p_next - pp[0]) > (p_next - p_left)) begin
            p_count--;
            pv[0] = pv[p_count];
            pp[0] = pp[p_count];
            heap_sink();
        end
        if (p_count == 0) begin
            res.max_value = '0;
            res.max_position = '0;
            if (st == ST_OK) st = ST_EMPTY;
        end else begin
            res.max_value = pv[0];
            res.max_position = pp[0];
        end
        res.status = st;
        return res;
    endfunction

    task automatic send_item(logic op, logic signed [31:0] value);
        in_item_t it;
        it.op = op;
        it.value = value;
        if (burst_mode && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        window_max_q.push_back(predict_window_max(it));
        if (window_max_q[$].status == ST_FULL) n_full++;
        if (window_max_q[$].status == ST_ADV_IGN) n_ign++;
        n_sent++;
        @(negedge aclk);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (window_max_q.size() != 0) @(negedge aclk);
        repeat (30) @(negedge aclk);
    endtask

    function automatic logic signed [31:0] rand_value();
        case ($urandom_range(0, 5))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return $urandom_range(0, 20) - 10;
            default: return $urandom;
        endcase
    endfunction

    // result checker
    always @(posedge aclk) begin
        out_item_t exp_r;
        if (aresetn && m_valid && m_ready) begin
            if (window_max_q.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result %h", m_data);
            end else begin
                exp_r = window_max_q.pop_front();
                n_checked++;
                if (m_data.max_value !== exp_r.max_value
                        || m_data.max_position !== exp_r.max_position
                        || m_data.status !== exp_r.status) begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: exp val %0d pos %0d st %0d, got val %0d pos %0d st %0d",
                                 exp_r.max_value, exp_r.max_position, exp_r.status,
                                 m_data.max_value, m_data.max_position, m_data.status);
                end
            end
        end
    end

    // receiver stall pattern
    always @(negedge aclk) begin
        if (hold_off) m_ready <= 1'b0;
        else m_ready <= ($urandom_range(0, 9) < 7) || !burst_mode;
    end

    task automatic test_directed();
        send_item(OP_ADVANCE, 0);          // empty advance
        send_item(OP_PUSH, 32'sh80000000);
        send_item(OP_PUSH, 32'sh7fffffff);
        send_item(OP_PUSH, 32'sh7fffffff); // tie keeps older
        send_item(OP_PUSH, -1);
        send_item(OP_PUSH, 0);
        repeat (5) send_item(OP_ADVANCE, 32'sh7fffffff);
        send_item(OP_ADVANCE, 0);
        send_item(OP_PUSH, 5);
        send_item(OP_PUSH, 3);
        send_item(OP_ADVANCE, 0);
        send_item(OP_ADVANCE, 0);
        drain();
    endtask

    // fill heap to capacity, then pushes get dropped
    task automatic test_heap_full();
        for (int i = 0; i < HEAP_DEPTH + 3; i++)
            send_item(OP_PUSH, (i < 4) ? rand_value() : -i);
        repeat (20) send_item(OP_ADVANCE, 0);
        drain();
    endtask

    task automatic test_backpressure();
        fork
            begin
                hold_off = 1'b1;
                repeat (200) @(negedge aclk);
                hold_off = 1'b0;
            end
            repeat (20) send_item(OP_PUSH, rand_value());
        join
        repeat (20) send_item(OP_ADVANCE, 0);
        drain();
    endtask

    task automatic test_random();
        int w;
        for (int i = 0; i < 60; i++) begin
            w = p_next - p_left;
            if (i % 20 == 0) burst_mode = $urandom_range(0, 3) != 0;
            if (w > 30) send_item($urandom_range(0, 2) != 0, rand_value());
            else send_item($urandom_range(0, 2) == 0, rand_value());
        end
        burst_mode = 1'b1;
        drain();
    endtask

    initial begin
        p_count = 0;
        p_left = '0;
        p_next = '0;
        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_directed();
        test_backpressure();
        test_random();
        test_heap_full();
        $display("Sent %0d items, checked %0d results (%0d full drops, %0d empty advances).",
                 n_sent, n_checked, n_full, n_ign);
        if (errors == 0 && window_max_q.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("FAIL");
        $finish;
    end
endmodule
